### design/q16sm_pkg.sv
// q16sm_pkg: types and constants shared by the Q16.16 saturating mul/div unit.
// No dependencies; every other design file imports it.
package q16sm_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Operation codes carried on cmd
  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_DIV = 1'b1;

  // Clamp values
  localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // Input beat
  typedef struct packed {
    logic                     cmd;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;
  } in_t;

  // Output beat
  typedef struct packed {
    logic signed [DATA_W-1:0] result;
    logic                     saturated;
    logic                     divided_by_zero;
  } out_t;

  // Per-item control that rides along the pipeline
  typedef struct packed {
    logic cmd;
    logic dz;     // divide with zero divisor
    logic qhi;    // quotient has bits above the result width
    logic a_neg;
    logic a_pos;
    logic b_neg;
    logic b_pos;
  } ctrl_t;

  // Pipeline stage payload.
  // Divide: rem is the partial remainder, dq holds the dividend bits still
  // to shift in (top) and the quotient bits made so far (bottom).
  // Multiply: {rem, dq} is the full product. Zero divisor: rem is operand_a.
  typedef struct packed {
    ctrl_t             ctrl;
    logic [DATA_W-1:0] divisor;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] dq;
  } stage_t;

endpackage

### design/q16sm_front.sv
// q16sm_front: first pipeline stage; multiply, operand magnitudes, divide setup.
// Depends on q16sm_pkg.
module q16sm_front #(
  parameter int FRAC_BITS = q16sm_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             vld_in,
  input  q16sm_pkg::in_t   op,
  output logic             vld,
  output q16sm_pkg::stage_t st
);
  import q16sm_pkg::*;

  logic [DATA_W-1:0]     abs_a;
  logic [DATA_W-1:0]     abs_b;
  logic [2*DATA_W-1:0]   dvd;
  logic signed [2*DATA_W-1:0] prod;
  stage_t                st_next;

  // Magnitudes; the most negative value maps to 2^31, which still fits
  assign abs_a = op.operand_a[DATA_W-1] ? (DATA_W'(0) - op.operand_a) : op.operand_a;
  assign abs_b = op.operand_b[DATA_W-1] ? (DATA_W'(0) - op.operand_b) : op.operand_b;

  // Scaled dividend |a| * 2^FRAC_BITS
  assign dvd  = {{DATA_W{1'b0}}, abs_a} << FRAC_BITS;
  assign prod = (2*DATA_W)'(op.operand_a) * (2*DATA_W)'(op.operand_b);

  always_comb begin
    st_next.ctrl.cmd   = op.cmd;
    st_next.ctrl.dz    = (op.cmd == CMD_DIV) && (op.operand_b == '0);
    st_next.ctrl.qhi   = dvd[2*DATA_W-1:DATA_W] >= abs_b;
    st_next.ctrl.a_neg = op.operand_a[DATA_W-1];
    st_next.ctrl.a_pos = !op.operand_a[DATA_W-1] && (op.operand_a != '0);
    st_next.ctrl.b_neg = op.operand_b[DATA_W-1];
    st_next.ctrl.b_pos = !op.operand_b[DATA_W-1] && (op.operand_b != '0);
    st_next.divisor    = abs_b;
    if (op.cmd == CMD_MUL) begin
      st_next.rem = prod[2*DATA_W-1:DATA_W];
      st_next.dq  = prod[DATA_W-1:0];
    end else if (st_next.ctrl.dz) begin
      st_next.rem = op.operand_a;
      st_next.dq  = '0;
    end else begin
      st_next.rem = dvd[2*DATA_W-1:DATA_W];
      st_next.dq  = dvd[DATA_W-1:0];
    end
  end

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

endmodule

### design/q16sm_div_stage.sv
// q16sm_div_stage: one restoring-division step, one quotient bit per stage.
// Depends on q16sm_pkg. Multiply and zero-divisor items pass unchanged.
module q16sm_div_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  q16sm_pkg::stage_t st_in,
  output logic              vld,
  output q16sm_pkg::stage_t st
);
  import q16sm_pkg::*;

  logic [DATA_W:0]   trial;
  logic              qbit;
  stage_t            st_next;

  // Shift in the next dividend bit and try to subtract the divisor
  assign trial = {st_in.rem, st_in.dq[DATA_W-1]} - {1'b0, st_in.divisor};
  assign qbit  = !trial[DATA_W];

  always_comb begin
    st_next = st_in;
    if (st_in.ctrl.cmd == CMD_DIV && !st_in.ctrl.dz) begin
      st_next.rem = qbit ? trial[DATA_W-1:0]
                         : {st_in.rem[DATA_W-2:0], st_in.dq[DATA_W-1]};
      st_next.dq  = {st_in.dq[DATA_W-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st <= st_next;
    end
  end

endmodule

### design/q16sm_result.sv
// q16sm_result: final stage; product scaling, quotient sign, zero-divisor flag, saturation.
// Depends on q16sm_pkg.
module q16sm_result #(
  parameter int FRAC_BITS = q16sm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              vld_in,
  input  q16sm_pkg::stage_t st_in,
  output logic              vld,
  output q16sm_pkg::out_t   res
);
  import q16sm_pkg::*;

  logic signed [2*DATA_W-1:0] sh;
  logic                       mul_fit;
  logic                       neg;
  logic                       div_fit;
  logic [DATA_W-1:0]          div_val;
  logic [DATA_W-1:0]          sat_val;
  out_t                       res_next;

  // Multiply: arithmetic shift rounds toward minus infinity
  assign sh      = $signed({st_in.rem, st_in.dq}) >>> FRAC_BITS;
  assign mul_fit = (&sh[2*DATA_W-1:DATA_W-1]) || !(|sh[2*DATA_W-1:DATA_W-1]);

  // Divide: magnitude quotient, negated when the signs differ
  assign neg     = st_in.ctrl.a_neg ^ st_in.ctrl.b_neg;
  assign div_fit = !st_in.ctrl.qhi &&
                   (neg ? (st_in.dq <= Q_MIN) : !st_in.dq[DATA_W-1]);
  assign div_val = neg ? (DATA_W'(0) - st_in.dq) : st_in.dq;

  assign sat_val = ((st_in.ctrl.a_neg && st_in.ctrl.b_pos) ||
                    (st_in.ctrl.a_pos && st_in.ctrl.b_neg)) ? Q_MIN : Q_MAX;

  always_comb begin
    res_next.divided_by_zero = 1'b0;
    res_next.saturated       = 1'b0;
    if (st_in.ctrl.cmd == CMD_MUL) begin
      res_next.saturated = !mul_fit;
      res_next.result    = mul_fit ? sh[DATA_W-1:0] : sat_val;
    end else if (st_in.ctrl.dz) begin
      res_next.divided_by_zero = 1'b1;
      res_next.result          = st_in.rem;
    end else begin
      res_next.saturated = !div_fit;
      res_next.result    = div_fit ? div_val : sat_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

### design/q16_16_saturating_mul_div.sv
// Signed Q16.16 saturating multiply / divide unit, fully pipelined.
// Input channel op (op_valid / op_stall / op): one beat per operation,
// cmd selects multiply or divide of operand_a by operand_b.
// Output channel res (res_valid / res_stall / res): one beat per input beat,
// in order, with result, saturated and divided_by_zero.
// Throughput: one beat per cycle while op_stall is low. The front stage
// with the multiplier loads at the accepting edge, then come 32
// restoring-division stages (one quotient bit each), one saturation stage
// and the output register.
// Multiply results round toward minus infinity, divide results truncate
// toward zero; out-of-range results clamp. A zero divisor returns operand_a.
// Reset (rst, synchronous) empties the pipeline and the output buffer.
// When res_stall holds a result, one more beat lands in a skid register and
// the pipeline then freezes, raising op_stall until the skid drains. No
// beat is lost or repeated.
// Depends on q16sm_pkg, q16sm_front, q16sm_div_stage, q16sm_result.
module q16_16_saturating_mul_div #(
  parameter int FRAC_BITS = q16sm_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            op_valid,
  output logic            op_stall,
  input  q16sm_pkg::in_t  op,
  output logic            res_valid,
  input  logic            res_stall,
  output q16sm_pkg::out_t res
);
  import q16sm_pkg::*;

  localparam int STEPS = DATA_W;

  logic   adv;
  logic   vld [0:STEPS];
  stage_t st  [0:STEPS];
  logic   fin_vld;
  out_t   fin;
  logic   skid_valid;
  out_t   skid;

  // Whole pipeline moves unless the skid register is occupied
  assign adv      = !skid_valid;
  assign op_stall = skid_valid;

  q16sm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_in (op_valid),
    .op     (op),
    .vld    (vld[0]),
    .st     (st[0])
  );

  // Division chain
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    q16sm_div_stage u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .vld_in (vld[i]),
      .st_in  (st[i]),
      .vld    (vld[i+1]),
      .st     (st[i+1])
    );
  end

  q16sm_result #(.FRAC_BITS(FRAC_BITS)) u_result (
    .clk    (clk),
    .rst    (rst),
    .en     (adv),
    .vld_in (vld[STEPS]),
    .st_in  (st[STEPS]),
    .vld    (fin_vld),
    .res    (fin)
  );

  // Output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || !res_stall) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= fin_vld;
      end
    end else if (fin_vld) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || !res_stall) begin
      res <= skid_valid ? skid : fin;
    end else if (adv && fin_vld) begin
      skid <= fin;
    end
  end

  // Skid is only used behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid register holds a beat with no output beat ahead");

  // The two flags exclude each other
  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.saturated && res.divided_by_zero))
    else $error("saturated and divided_by_zero both set");

  // A clamped result is one of the two limits
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.saturated) |-> (res.result == Q_MAX || res.result == Q_MIN))
    else $error("saturated result is not a clamp value");

endmodule
